FILE: hdl/server_table_load_balancer_core_defines.svh
// Assertion macros for the server table load balancer
`ifndef SERVER_TABLE_LOAD_BALANCER_CORE_DEFINES_SVH
`define SERVER_TABLE_LOAD_BALANCER_CORE_DEFINES_SVH
`ifndef SYNTH
`define STLB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define STLB_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define STLB_ASSERT(label, clk, rst_n, prop)
`define STLB_ASSERT_NR(label, clk, prop)
`endif
`endif

FILE: hdl/stlb_pkg.sv
package stlb_pkg;
    localparam int MaxServers = 16;
    localparam int IdxW = $clog2(MaxServers);
    localparam int CntW = $clog2(MaxServers + 1);

    localparam logic [2:0] ACT_REGISTER = 3'd0;
    localparam logic [2:0] ACT_UNREG    = 3'd1;
    localparam logic [2:0] ACT_SEL_RR   = 3'd2;
    localparam logic [2:0] ACT_SEL_ZONE = 3'd3;
    localparam logic [2:0] ACT_UPDATE   = 3'd4;
    localparam logic [2:0] ACT_BEAT     = 3'd5;
    localparam logic [2:0] ACT_PRUNE    = 3'd6;
    localparam logic [2:0] ACT_TICK     = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] server_id;
        logic [7:0]  zone_id;
        logic [15:0] max_load;
        logic [15:0] load_value;
        logic        available_in;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [15:0] chosen_id;
        logic [15:0] chosen_load;
        logic [1:0]  status;
        logic [4:0]  server_count;
        logic [4:0]  pruned_count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // latch request, clear scan state
        logic step;       // process the entry at the scan index
        logic finish;     // commit counts, build the response
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;  // no more entries to visit
    } t_sts;
endpackage

FILE: hdl/stlb_ctrl.sv
module stlb_ctrl
    import stlb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_rsp_valid, n_rsp_valid;

    // take a new request once the previous response is gone or leaving
    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign o_rsp_valid = r_rsp_valid;

    always_comb begin
        n_state = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && o_req_ready) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_rsp_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

`include "server_table_load_balancer_core_defines.svh"
    `STLB_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_req_ready)
    `STLB_ASSERT(a_done_to_idle, i_clk, i_rst_n, (r_state == S_DONE) |=> (r_state == S_IDLE) && r_rsp_valid)
    `STLB_ASSERT(a_cmd_excl, i_clk, i_rst_n, $onehot0(o_cmd))
endmodule

FILE: hdl/stlb_dp.sv
module stlb_dp
    import stlb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output t_sts        o_sts,
    output t_rsp        o_rsp
);
    logic [15:0] r_id    [MaxServers];
    logic [7:0]  r_zone  [MaxServers];
    logic [15:0] r_limit [MaxServers];
    logic [15:0] r_ld    [MaxServers];
    logic        r_avail [MaxServers];
    logic [31:0] r_beat  [MaxServers];

    logic [CntW-1:0] r_count, r_wr, r_rd;
    logic [IdxW-1:0] r_rr, r_rr_start;
    logic [31:0]     r_now;
    logic [15:0]     r_timeout;
    t_req            r_req;
    logic            r_found, r_full, r_visited;
    logic [15:0]     r_cid, r_cload;
    logic [CntW-1:0] r_pruned;
    t_rsp            r_rsp;

    logic [IdxW-1:0] rd_idx, cur, rr_next;
    logic            elig, hit, drop, rr_active, rr_wrap;
    logic [31:0]     age;
    logic [CntW-1:0] n_count;

    // round robin walks from the pointer; others walk from entry 0
    assign rr_active = (r_req.action == ACT_SEL_RR);
    assign cur = rr_active ? r_rr : r_rd[IdxW-1:0];
    assign rd_idx = cur;
    assign elig = r_avail[rd_idx] && (r_ld[rd_idx] < r_limit[rd_idx]);
    assign hit = (r_id[rd_idx] == r_req.server_id);
    assign age = r_now - r_beat[rd_idx];
    assign drop = (r_req.action == ACT_UNREG) ? hit : (age > {16'd0, r_timeout});
    assign rr_wrap = ({1'b0, r_rr} + 1'b1) >= r_count;
    assign rr_next = rr_wrap ? '0 : r_rr + 1'b1;

    always_comb begin
        o_sts.scan_done = 1'b1;
        unique case (r_req.action)
            ACT_UNREG, ACT_PRUNE, ACT_SEL_ZONE:
                o_sts.scan_done = (r_rd >= r_count);
            ACT_REGISTER, ACT_UPDATE, ACT_BEAT:
                o_sts.scan_done = r_found || (r_rd >= r_count);
            ACT_SEL_RR:
                o_sts.scan_done = r_found || (r_count == '0)
                                  || (r_visited && r_rr == r_rr_start);
            default: o_sts.scan_done = 1'b1;
        endcase
    end

    assign n_count = (r_req.action == ACT_UNREG || r_req.action == ACT_PRUNE) ? r_wr
        : (r_req.action == ACT_REGISTER && !r_found && r_count < CntW'(MaxServers))
          ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            unique case (r_req.action)
                ACT_UNREG, ACT_PRUNE: if (!drop && r_wr != r_rd) begin
                    r_id[r_wr[IdxW-1:0]] <= r_id[rd_idx];
                    r_zone[r_wr[IdxW-1:0]] <= r_zone[rd_idx];
                    r_limit[r_wr[IdxW-1:0]] <= r_limit[rd_idx];
                    r_ld[r_wr[IdxW-1:0]] <= r_ld[rd_idx];
                    r_avail[r_wr[IdxW-1:0]] <= r_avail[rd_idx];
                    r_beat[r_wr[IdxW-1:0]] <= r_beat[rd_idx];
                end
                ACT_REGISTER: if (hit) begin
                    r_zone[rd_idx] <= r_req.zone_id;
                    r_limit[rd_idx] <= r_req.max_load;
                    r_ld[rd_idx] <= r_req.load_value;
                    r_avail[rd_idx] <= r_req.available_in;
                    r_beat[rd_idx] <= r_now;
                end
                ACT_UPDATE, ACT_BEAT: if (hit) begin
                    r_ld[rd_idx] <= r_req.load_value;
                    if (r_req.action == ACT_BEAT) begin
                        r_beat[rd_idx] <= r_now;
                        r_avail[rd_idx] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // append a new entry at the end of the table
        if (i_cmd.finish && r_req.action == ACT_REGISTER && !r_found
            && r_count < CntW'(MaxServers)) begin
            r_id[r_count[IdxW-1:0]] <= r_req.server_id;
            r_zone[r_count[IdxW-1:0]] <= r_req.zone_id;
            r_limit[r_count[IdxW-1:0]] <= r_req.max_load;
            r_ld[r_count[IdxW-1:0]] <= r_req.load_value;
            r_avail[r_count[IdxW-1:0]] <= r_req.available_in;
            r_beat[r_count[IdxW-1:0]] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.finish) begin
            r_rsp.found <= r_found;
            // a select that found nothing answers with zero id and load
            r_rsp.chosen_id <= (r_found && (r_req.action == ACT_SEL_RR
                                || r_req.action == ACT_SEL_ZONE)) ? r_cid : 16'd0;
            r_rsp.chosen_load <= (r_found && (r_req.action == ACT_SEL_RR
                                  || r_req.action == ACT_SEL_ZONE)) ? r_cload : 16'd0;
            r_rsp.status <= r_full ? ST_FULL
                : (r_req.action == ACT_REGISTER || r_req.action == ACT_PRUNE
                   || r_req.action == ACT_TICK || r_found) ? ST_OK : ST_NOMATCH;
            r_rsp.server_count <= 5'(n_count);
            r_rsp.pruned_count <= (r_req.action == ACT_PRUNE) ? 5'(r_pruned) : 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rr <= '0;
            r_now <= '0;
            r_timeout <= 16'd30;
            r_rd <= '0;
            r_wr <= '0;
            r_found <= 1'b0;
            r_full <= 1'b0;
            r_visited <= 1'b0;
            r_pruned <= '0;
            r_rr_start <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.load_req) begin
                r_rd <= '0;
                r_wr <= '0;
                r_found <= 1'b0;
                r_full <= 1'b0;
                r_visited <= 1'b0;
                r_pruned <= '0;
                // pointer past end wraps before a round-robin walk
                if ({1'b0, r_rr} >= r_count) begin
                    r_rr <= '0;
                    r_rr_start <= '0;
                end else begin
                    r_rr_start <= r_rr;
                end
            end
            if (i_cmd.step) begin
                r_rd <= r_rd + 1'b1;
                unique case (r_req.action)
                    ACT_UNREG, ACT_PRUNE: begin
                        if (drop) begin
                            if (r_req.action == ACT_UNREG) r_found <= 1'b1;
                            else r_pruned <= r_pruned + 1'b1;
                        end else begin
                            r_wr <= r_wr + 1'b1;
                        end
                    end
                    ACT_REGISTER, ACT_UPDATE, ACT_BEAT: if (hit) r_found <= 1'b1;
                    ACT_SEL_ZONE: begin
                        if (r_zone[rd_idx] == r_req.zone_id && elig
                            && (!r_found || r_ld[rd_idx] < r_cload)) begin
                            r_found <= 1'b1;
                            r_cid <= r_id[rd_idx];
                            r_cload <= r_ld[rd_idx];
                        end
                    end
                    ACT_SEL_RR: begin
                        r_visited <= 1'b1;
                        r_rr <= rr_next;
                        if (elig) begin
                            r_found <= 1'b1;
                            r_cid <= r_id[rd_idx];
                            r_cload <= r_ld[rd_idx];
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
                if (r_req.action == ACT_TICK) r_now <= r_now + 32'd1;
                if (r_req.action == ACT_REGISTER && !r_found
                    && r_count >= CntW'(MaxServers)) r_full <= 1'b1;
                if ((r_req.action == ACT_UNREG || r_req.action == ACT_PRUNE)
                    && {1'b0, r_rr} >= r_wr) r_rr <= '0;
            end
        end
    end

    // full flag is set at finish; fold it into status through a side path
    always_comb begin
        o_rsp = r_rsp;
        if (r_full) o_rsp.status = ST_FULL;
    end

`include "server_table_load_balancer_core_defines.svh"
    `STLB_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CntW'(MaxServers))
    `STLB_ASSERT(a_wr_le_rd, i_clk, i_rst_n, r_wr <= r_rd)
    `STLB_ASSERT(a_rr_in_range, i_clk, i_rst_n, i_cmd.finish |=> (r_count == '0) || ({1'b0, r_rr} < r_count) || (r_req.action == ACT_REGISTER) || (r_req.action == ACT_TICK))
endmodule

FILE: hdl/server_table_load_balancer_core.sv
// channel   | direction | payload
// s_axis    | in        | request: action, server_id, zone_id, max_load, load_value, available
// m_axis    | out       | response: found, id, load, status, count, pruned
// cfg       | in        | stale_timeout
// An action latches the request, walks the table entries in turn, sees the
// walk end and then builds the response. Lookups stop at the first id match;
// round-robin stops at the first eligible entry.
// Synchronous active-low reset empties the table. The response register
// holds while m_axis_tready is low; no new request is taken until it leaves.
module server_table_load_balancer_core
    import stlb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], server_id[18:3], zone_id[26:19], max_load[42:27],
    // load_value[58:43], available_in[59], zero fill to 64
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found[0], chosen_id[16:1], chosen_load[32:17], status[34:33],
    // server_count[39:35], pruned_count[44:40], zero fill to 48
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    t_req req;
    t_rsp rsp;

    assign req.action       = s_axis_tdata[2:0];
    assign req.server_id    = s_axis_tdata[18:3];
    assign req.zone_id      = s_axis_tdata[26:19];
    assign req.max_load     = s_axis_tdata[42:27];
    assign req.load_value   = s_axis_tdata[58:43];
    assign req.available_in = s_axis_tdata[59];

    assign o_cfg_ready = 1'b1;
    assign m_axis_tdata = {3'd0, rsp.pruned_count, rsp.server_count, rsp.status,
                           rsp.chosen_load, rsp.chosen_id, rsp.found};

    stlb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready),
        .o_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    stlb_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_req(req),
        .i_cfg_we(i_cfg_valid), .i_cfg_data,
        .o_sts(sts), .o_rsp(rsp)
    );
endmodule
